FILE: rtl/sma_pkg.sv
// Package: shared types, constants and codes for the stack machine ALU.
`default_nettype none
package sma_pkg;
    localparam int WordBits = 32;
    localparam int AddrBits = 16;
    localparam int NspBits  = AddrBits + 1;
    localparam int DivSteps = WordBits;

    typedef enum logic [2:0] {
        OP_NOP = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2,
        OP_MUL = 3'd3, OP_DIV = 3'd4, OP_CMP = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNDERFLOW = 2'd1, ST_DIV_ZERO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FC_EQUAL = 2'd0, FC_GREATER = 2'd1, FC_OTHER = 2'd2
    } t_flag;

    // Classified instruction handed from the front end to the back end.
    typedef struct packed {
        logic                       do_write;   // arithmetic with a result
        logic                       is_mul;
        logic                       is_div;
        logic                       flag_write;
        logic [1:0]                 flag_code;
        logic [NspBits-1:0]         nsp;
        logic [1:0]                 status;
        logic signed [WordBits-1:0] quick;      // add/sub result
        logic [WordBits-1:0]        next_v;
        logic [WordBits-1:0]        top_v;
    } t_cmd;

    typedef struct packed {
        logic [WordBits-1:0] value;
        logic                rw;
        logic                fw;
        logic [1:0]          fc;
        logic [NspBits-1:0]  nsp;
        logic [1:0]          status;
    } t_res;
endpackage
`default_nettype wire

FILE: rtl/sma_front.sv
// Front end: accepts instructions, checks the stack and classifies them.
`default_nettype none
module sma_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [2:0]                     i_op,
    input  wire logic [sma_pkg::WordBits-1:0]   i_top,
    input  wire logic [sma_pkg::WordBits-1:0]   i_next,
    input  wire logic [sma_pkg::AddrBits-1:0]   i_sp,
    input  wire logic [sma_pkg::AddrBits-1:0]   i_bottom,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output sma_pkg::t_cmd                       o_cmd
);
    logic          r_valid;
    sma_pkg::t_cmd r_cmd, n_cmd;
    logic [sma_pkg::NspBits-1:0] sp1, sp2, bot;
    logic arith;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        sp1   = {1'b0, i_sp} + sma_pkg::NspBits'(1);
        sp2   = {1'b0, i_sp} + sma_pkg::NspBits'(2);
        bot   = {1'b0, i_bottom};
        arith = (i_op == sma_pkg::OP_ADD) || (i_op == sma_pkg::OP_SUB)
             || (i_op == sma_pkg::OP_MUL) || (i_op == sma_pkg::OP_DIV);
        n_cmd = '0;
        n_cmd.nsp    = {1'b0, i_sp};
        n_cmd.next_v = i_next;
        n_cmd.top_v  = i_top;
        if (arith) begin
            n_cmd.nsp = sp1;
            if (sp1 >= bot) begin
                n_cmd.status = sma_pkg::ST_UNDERFLOW;
            end else if (i_op == sma_pkg::OP_DIV && i_top == '0) begin
                n_cmd.status = sma_pkg::ST_DIV_ZERO;
            end else begin
                n_cmd.do_write = 1'b1;
                n_cmd.is_mul   = (i_op == sma_pkg::OP_MUL);
                n_cmd.is_div   = (i_op == sma_pkg::OP_DIV);
                n_cmd.quick    = (i_op == sma_pkg::OP_SUB) ? i_next - i_top
                                                          : i_next + i_top;
            end
        end else if (i_op == sma_pkg::OP_CMP) begin
            n_cmd.nsp = sp2;
            if (sp2 > bot) begin
                n_cmd.status = sma_pkg::ST_UNDERFLOW;
            end else begin
                n_cmd.flag_write = 1'b1;
                if (i_next == i_top)
                    n_cmd.flag_code = sma_pkg::FC_EQUAL;
                else if ($signed(i_next) > $signed(i_top))
                    n_cmd.flag_code = sma_pkg::FC_GREATER;
                else
                    n_cmd.flag_code = sma_pkg::FC_OTHER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/sma_back.sv
// Back end: stall-able pipeline with a multiplier and a one-bit-per-stage divider.
`default_nettype none
module sma_back (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  sma_pkg::t_cmd i_cmd,
    output logic        o_valid,
    input  wire logic   i_ready,
    output sma_pkg::t_res o_res
);
    localparam int W = sma_pkg::WordBits;
    localparam int N = sma_pkg::DivSteps;

    // Stage 0: operand magnitudes and signs; stages 1..N: one quotient bit each;
    // stage N+1: sign fix and final pick.
    logic                r_v  [0:N+1];
    sma_pkg::t_cmd       r_c  [0:N];
    logic [W-1:0]        r_rem [0:N];
    logic [W-1:0]        r_quo [0:N];
    logic [W-1:0]        r_den [0:N];
    logic                r_neg [0:N];
    logic [W-1:0]        r_prod;
    sma_pkg::t_res       r_out;
    logic                adv;
    logic [W-1:0]        na, nb;

    assign adv     = !r_v[N+1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[N+1];
    assign o_res   = r_out;

    always_comb begin
        na = i_cmd.next_v[W-1] ? W'(-i_cmd.next_v) : i_cmd.next_v;
        nb = i_cmd.top_v[W-1]  ? W'(-i_cmd.top_v)  : i_cmd.top_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N + 1; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= N + 1; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c[0]   <= i_cmd;
            r_rem[0] <= '0;
            r_quo[0] <= na;
            r_den[0] <= nb;
            r_neg[0] <= i_cmd.next_v[W-1] ^ i_cmd.top_v[W-1];
            r_prod   <= W'(i_cmd.next_v * i_cmd.top_v);
        end
    end

    genvar g;
    generate
        for (g = 1; g <= N; g++) begin : g_div
            logic [W:0] t;
            assign t = {r_rem[g-1], r_quo[g-1][W-1]} - {1'b0, r_den[g-1]};
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_c[g]   <= r_c[g-1];
                    r_den[g] <= r_den[g-1];
                    r_neg[g] <= r_neg[g-1];
                    if (!t[W]) begin
                        r_rem[g] <= t[W-1:0];
                        r_quo[g] <= {r_quo[g-1][W-2:0], 1'b1};
                    end else begin
                        r_rem[g] <= {r_rem[g-1][W-2:0], r_quo[g-1][W-1]};
                        r_quo[g] <= {r_quo[g-1][W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // product rides along the pipe
    logic [W-1:0] r_pd [1:N];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pd[1] <= r_prod;
            for (int k = 2; k <= N; k++) r_pd[k] <= r_pd[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.rw     <= r_c[N].do_write;
            r_out.fw     <= r_c[N].flag_write;
            r_out.fc     <= r_c[N].flag_code;
            r_out.nsp    <= r_c[N].nsp;
            r_out.status <= r_c[N].status;
            if (!r_c[N].do_write)
                r_out.value <= '0;
            else if (r_c[N].is_div)
                r_out.value <= r_neg[N] ? W'(-r_quo[N]) : r_quo[N];
            else if (r_c[N].is_mul)
                r_out.value <= r_pd[N];
            else
                r_out.value <= r_c[N].quick;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/stack_machine_alu.sv
// Top level: stack machine ALU with decoupled front end and execution pipeline.
//
// One instruction is taken per cycle and one result leaves per cycle while
// m_tready stays high. The front end checks stack bounds against stack_bottom
// and classifies the instruction into a register slice; the back end runs a
// pipeline whose depth is set by the radix-2 divider, one quotient bit per
// stage. Multiply, add and compare ride the same pipe so results stay in
// order. Either side may stall on its own: the pipeline holds while a result
// waits and m_tready is low. The user must write stack_bottom (i_cfg_wdata)
// with i_cfg_we only while the block is idle; the block does not enforce it.
`default_nettype none
module stack_machine_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,   // stack_bottom
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,       // operation[2:0], top_value[34:3],
                                            // next_value[66:35], stack_pointer[82:67]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata        // result_value[31:0], result_write[32],
                                            // flag_write[33], flag_code[35:34],
                                            // new_stack_pointer[52:36], status[54:53]
);
    logic [15:0]   r_bottom;
    logic          q_valid, q_ready;
    sma_pkg::t_cmd q_cmd;
    sma_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom <= 16'hFFFF;
        end else if (i_cfg_we) begin
            r_bottom <= i_cfg_wdata;
        end
    end

    sma_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (s_tvalid), .o_ready (s_tready),
        .i_op    (s_tdata[2:0]),
        .i_top   (s_tdata[34:3]),
        .i_next  (s_tdata[66:35]),
        .i_sp    (s_tdata[82:67]),
        .i_bottom(r_bottom),
        .o_valid (q_valid), .i_ready (q_ready), .o_cmd (q_cmd)
    );

    sma_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid), .o_ready (q_ready), .i_cmd (q_cmd),
        .o_valid (m_tvalid), .i_ready (m_tready), .o_res (res)
    );

    assign m_tdata = {1'b0, res.status, res.nsp, res.fc, res.fw, res.rw, res.value};
endmodule
`default_nettype wire

FILE: tb/sv/stack_machine_alu_checker.sv
// Checker: watches both stream channels, predicts each result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module stack_machine_alu_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);
    logic [sma_pkg::AddrBits-1:0] bottom_q;
    sma_pkg::t_res                expected_results[$];

    function automatic logic [sma_pkg::WordBits-1:0] quotient_of(
        logic [sma_pkg::WordBits-1:0] n, logic [sma_pkg::WordBits-1:0] d);
        logic [sma_pkg::WordBits-1:0] mn, md, q;
        mn = n[sma_pkg::WordBits-1] ? -n : n;
        md = d[sma_pkg::WordBits-1] ? -d : d;
        q  = mn / md;
        return (n[sma_pkg::WordBits-1] ^ d[sma_pkg::WordBits-1]) ? -q : q;
    endfunction

    function automatic sma_pkg::t_res execute_instr(logic [87:0] d,
                                                    logic [sma_pkg::AddrBits-1:0] bottom);
        sma_pkg::t_op                 op;
        logic [sma_pkg::WordBits-1:0] top, nxt;
        logic [sma_pkg::NspBits-1:0]  sp;
        sma_pkg::t_res                r;
        op  = sma_pkg::t_op'(d[2:0]);
        top = d[34:3];
        nxt = d[66:35];
        sp  = {1'b0, d[82:67]};
        r   = '0;
        r.nsp    = sp;
        r.status = sma_pkg::ST_OK;
        case (op)
            sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV: begin
                r.nsp = sp + sma_pkg::NspBits'(1);
                if (r.nsp >= {1'b0, bottom}) r.status = sma_pkg::ST_UNDERFLOW;
                else if (op == sma_pkg::OP_DIV && top == '0)
                    r.status = sma_pkg::ST_DIV_ZERO;
                else begin
                    r.rw = 1'b1;
                    case (op)
                        sma_pkg::OP_ADD: r.value = nxt + top;
                        sma_pkg::OP_SUB: r.value = nxt - top;
                        sma_pkg::OP_MUL: r.value = nxt * top;
                        default:         r.value = quotient_of(nxt, top);
                    endcase
                end
            end
            sma_pkg::OP_CMP: begin
                r.nsp = sp + sma_pkg::NspBits'(2);
                if (r.nsp > {1'b0, bottom}) r.status = sma_pkg::ST_UNDERFLOW;
                else begin
                    r.fw = 1'b1;
                    if (nxt == top) r.fc = sma_pkg::FC_EQUAL;
                    else if ($signed(nxt) > $signed(top)) r.fc = sma_pkg::FC_GREATER;
                    else r.fc = sma_pkg::FC_OTHER;
                end
            end
            default: ; // nop and unused codes
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        sma_pkg::t_res want, got;
        if (!i_rst_n) begin
            bottom_q       <= 16'hFFFF;
            o_fail_count   <= 0;
            o_result_count <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) bottom_q <= i_cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_instr(s_tdata, bottom_q));
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata[31:0];
                got.rw     = m_tdata[32];
                got.fw     = m_tdata[33];
                got.fc     = m_tdata[35:34];
                got.nsp    = m_tdata[52:36];
                got.status = m_tdata[54:53];
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want || m_tdata[55] !== 1'b0) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.value != want.value)
                            $error("result_value exp %h got %h", want.value, got.value);
                        if (got.rw != want.rw)
                            $error("result_write exp %0d got %0d", want.rw, got.rw);
                        if (got.fw != want.fw)
                            $error("flag_write exp %0d got %0d", want.fw, got.fw);
                        if (got.fc != want.fc)
                            $error("flag_code exp %0d got %0d", want.fc, got.fc);
                        if (got.nsp != want.nsp)
                            $error("new_stack_pointer exp %0d got %0d", want.nsp, got.nsp);
                        if (got.status != want.status)
                            $error("status exp %0d got %0d", want.status, got.status);
                        if (m_tdata[55] !== 1'b0)
                            $error("pad bit exp 0 got %b", m_tdata[55]);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: tb/sv/stack_machine_alu_test.sv
// Testbench top: drives instructions and stack_bottom settings, gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module stack_machine_alu_test;
    localparam int Latency  = 34;
    localparam int IdleLimit = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    int          fail_count, pending, result_count;
    int          sent_count = 0;
    int          idle_cycles = 0;
    bit          rx_done = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    stack_machine_alu dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    stack_machine_alu_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Watchdog: cycles without any transfer on either channel.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no transfer for %0d cycles", IdleLimit);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: holds m_tready low for a random stall before each transfer;
    // some transfers get no stall at all.
    initial begin : result_sink
        int gap;
        @(posedge clk iff rst_n);
        while (!rx_done) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            repeat (gap) @(posedge clk);
            m_tready <= 1'b1;
            @(posedge clk iff m_tvalid || rx_done);
            m_tready <= 1'b0;
        end
    end

    task automatic send_instr(sma_pkg::t_op op, logic [31:0] top, logic [31:0] nxt,
                              logic [15:0] sp, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, sp, nxt, top, 3'(op)};
        @(posedge clk iff s_tready);
        sent_count++;
    endtask

    // Drain, then let the pipe settle before touching stack_bottom.
    task automatic set_bottom(logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk iff pending == 0);
        repeat (Latency + 4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Stack pointer near the bottom so both underflow and ok show up.
    function automatic logic [15:0] pick_sp(logic [15:0] bottom);
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return bottom - 16'($urandom_range(0, 4));
    endfunction

    initial begin : stimulus
        logic [15:0]  bottoms[5];
        logic [31:0]  w;
        sma_pkg::t_op op;
        bit           burst;
        bottoms = '{16'h0000, 16'h0001, 16'h0010, 16'h8000, 16'hFFFF};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset value of stack_bottom, field extremes, every op
        send_instr(sma_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1);
        send_instr(sma_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 1);
        send_instr(sma_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 16'h1234, 0);
        send_instr(sma_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFD, 0);
        send_instr(sma_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000, 16'hFFFE, 0); // underflow
        send_instr(sma_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000, 16'h0005, 0); // min / -1
        send_instr(sma_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0064, 16'h0005, 0); // div by 0
        send_instr(sma_pkg::OP_DIV, 32'h0000_0007, 32'hFFFF_FFF9 - 32'd1, 16'h0005, 0);
        send_instr(sma_pkg::OP_DIV, 32'hFFFF_FFFD, 32'h0000_0007, 16'h0005, 1);
        send_instr(sma_pkg::OP_CMP, 32'h5, 32'h5, 16'hFFFD, 0);              // equal
        send_instr(sma_pkg::OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 0); // greater
        send_instr(sma_pkg::OP_CMP, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 0); // other
        send_instr(sma_pkg::OP_CMP, 32'h0, 32'h0, 16'hFFFE, 0);              // underflow
        send_instr(sma_pkg::t_op'(3'd6), 32'h1, 32'h2, 16'h0100, 0);
        send_instr(sma_pkg::t_op'(3'd7), 32'h1, 32'h2, 16'hFFFF, 0);

        // Random phases over several stack_bottom settings
        for (int phase = 0; phase < 6; phase++) begin
            logic [15:0] bottom;
            bottom = (phase < 5) ? bottoms[phase] : 16'($urandom);
            set_bottom(bottom);
            for (int i = 0; i < 90; i++) begin
                op    = sma_pkg::t_op'(3'(($urandom_range(0, 19) == 0)
                                           ? $urandom_range(6, 7)
                                           : $urandom_range(0, 5)));
                w     = pick_word();
                if (op == sma_pkg::OP_DIV && $urandom_range(0, 9) != 0 && w == 0)
                    w = 32'd3;
                burst = (i % 30) >= 20;
                send_instr(op, w, pick_word(), pick_sp(bottom), burst);
            end
        end
        set_bottom(16'hFFFF);
        s_tvalid <= 1'b0;

        @(posedge clk iff pending == 0);
        repeat (Latency + 4) @(posedge clk);
        rx_done = 1'b1;
        $display("sent %0d instructions over 7 stack_bottom settings, checked %0d results",
                 sent_count, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
